FILE: hw/rtl/alrp_pkg.sv
package alrp_pkg;

	localparam int SAMPLE_W = 24;

	// looper modes
	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_REC  = 2'd1;
	localparam logic [1:0] MODE_PLAY = 2'd2;

	// click events
	localparam logic [1:0] CLICK_NONE   = 2'd0;
	localparam logic [1:0] CLICK_SINGLE = 2'd1;
	localparam logic [1:0] CLICK_DOUBLE = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_HOLDOFF  = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_DCLICK   = 2'd2;

	// blink phase: bit 0 of t/500 = bit 0 of (t>>2)/125, via reciprocal ceil(2^37/125)
	localparam int          BLINK_SHIFT = 37;
	localparam logic [30:0] BLINK_RECIP = 31'd1099511628;

	typedef struct packed {
		logic                       kind;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [15:0]                loop_gain;
		logic                       button_level;
		logic [31:0]                time_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [1:0]                 looper_mode;
		logic [1:0]                 click_event;
		logic                       led_on;
	} out_item_t;

endpackage

FILE: hw/rtl/audio_looper_record_play_top.sv
// Single-channel audio looper with one button and a status LED.
// Input channel (in_valid / in_stall / in_data) carries either an audio request
// (kind 0: dry sample and Q1.15 loop gain) or a button request (kind 1: level and
// time in ms). Every request gives exactly one result on the output channel
// (out_valid / out_stall / out_data): the mixed sample, the mode, the click event
// and the LED state after that request.
// Throughput is one request per cycle unless out_stall holds the pipeline.
// Stages: loop memory read, loop sample times gain, then add and saturate.
// Mode, position and click decisions are settled in the acceptance cycle, so
// requests can follow each other with no gap.
// The three timing registers sit on an APB port at byte addresses 0, 4 and 8;
// write them only while no request is in flight.
// Reset clears mode, position, loop length, click time and LED and restores the
// register defaults. The loop memory is not cleared; playback only reads
// entries recorded since the last record start.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; the result stays in place until taken.
module audio_looper_record_play_top
	import alrp_pkg::*;
#(
	parameter int LOOP_DEPTH = 2097152
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int POS_W  = $clog2(LOOP_DEPTH + 1);
	localparam int ADDR_W = $clog2(LOOP_DEPTH);
	localparam logic [POS_W-1:0] DEPTH_P = POS_W'(LOOP_DEPTH);

	// architectural state
	logic [1:0]       mode_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len_q;
	logic             prev_level_q;
	logic [31:0]      last_click_q;
	logic             led_q;
	logic [15:0]      holdoff_q;
	logic [15:0]      debounce_q;
	logic [15:0]      dclick_q;

	logic [SAMPLE_W-1:0] loop_mem [LOOP_DEPTH];

	logic adv;
	logic accept;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// ---------------- control decisions at acceptance ----------------
	logic [1:0]       mode_cur;
	logic [31:0]      elapsed;
	logic             click_hit;
	logic [1:0]       click;
	logic [1:0]       mode_nx;
	logic [POS_W-1:0] pos_nx;
	logic [POS_W-1:0] len_nx;
	logic [POS_W-1:0] rd_pos;
	logic [POS_W-1:0] rd_inc;
	logic             rec_wr;
	logic             play;
	logic             led_nx;
	logic [60:0]      blink_prod;

	assign mode_cur  = (mode_q == MODE_REC || mode_q == MODE_PLAY) ? mode_q : MODE_OFF;
	assign elapsed   = in_data.time_ms - last_click_q;
	assign click_hit = in_data.kind && (in_data.time_ms >= {16'd0, holdoff_q})
		&& (elapsed > {16'd0, debounce_q}) && !prev_level_q && in_data.button_level;
	assign click     = !click_hit ? CLICK_NONE :
		(elapsed < {16'd0, dclick_q}) ? CLICK_DOUBLE : CLICK_SINGLE;

	assign blink_prod = 61'(in_data.time_ms[31:2]) * 61'(BLINK_RECIP);

	always_comb begin
		mode_nx = mode_cur;
		pos_nx  = pos_q;
		len_nx  = len_q;
		rd_pos  = '0;
		rd_inc  = '0;
		rec_wr  = 1'b0;
		play    = 1'b0;
		if (in_data.kind) begin
			case (click)
				CLICK_SINGLE: begin
					case (mode_cur)
						MODE_OFF: begin
							mode_nx = MODE_REC;
							pos_nx  = '0;
						end
						MODE_REC: begin
							mode_nx = MODE_PLAY;
							len_nx  = pos_q;
							pos_nx  = '0;
						end
						default: mode_nx = MODE_OFF;
					endcase
				end
				CLICK_DOUBLE: mode_nx = MODE_OFF;
				default: ;
			endcase
		end else begin
			case (mode_cur)
				MODE_REC: begin
					if (pos_q < DEPTH_P) begin
						rec_wr = 1'b1;
						pos_nx = pos_q + 1'b1;
					end
				end
				MODE_PLAY: begin
					if (len_q != '0) begin
						play   = 1'b1;
						rd_pos = (pos_q >= len_q || pos_q >= DEPTH_P) ? '0 : pos_q;
						rd_inc = rd_pos + 1'b1;
						pos_nx = (rd_inc >= len_q) ? '0 : rd_inc;
					end
				end
				default: pos_nx = '0;
			endcase
		end
	end

	always_comb begin
		led_nx = led_q;
		if (in_data.kind) begin
			case (mode_nx)
				MODE_PLAY: led_nx = 1'b1;
				MODE_REC:  led_nx = !blink_prod[BLINK_SHIFT];
				default:   led_nx = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			pos_q        <= '0;
			len_q        <= '0;
			prev_level_q <= 1'b0;
			last_click_q <= '0;
			led_q        <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_nx;
			pos_q  <= pos_nx;
			len_q  <= len_nx;
			led_q  <= led_nx;
			if (in_data.kind) begin
				prev_level_q <= in_data.button_level;
			end
			if (click != CLICK_NONE) begin
				last_click_q <= in_data.time_ms;
			end
		end
	end

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q  <= 16'd1000;
			debounce_q <= 16'd500;
			dclick_q   <= 16'd500;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_HOLDOFF:  holdoff_q  <= pwdata[15:0];
				REG_DEBOUNCE: debounce_q <= pwdata[15:0];
				REG_DCLICK:   dclick_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HOLDOFF:  prdata = {16'd0, holdoff_q};
			REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			REG_DCLICK:   prdata = {16'd0, dclick_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------- loop memory ----------------
	logic [SAMPLE_W-1:0] rdat_s1;

	always_ff @(posedge clk) begin
		if (accept && rec_wr) begin
			loop_mem[pos_q[ADDR_W-1:0]] <= in_data.sample_in;
		end
		if (accept && play) begin
			rdat_s1 <= loop_mem[rd_pos[ADDR_W-1:0]];
		end
	end

	// ---------------- datapath pipeline ----------------
	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] dry_s1;
	logic [15:0]                gain_s1;
	logic                       play_s1;
	logic [1:0]                 mode_s1;
	logic [1:0]                 click_s1;
	logic                       led_s1;

	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] dry_s2;
	logic signed [SAMPLE_W+16:0] prod_s2;
	logic                       play_s2;
	logic [1:0]                 mode_s2;
	logic [1:0]                 click_s2;
	logic                       led_s2;

	logic                       out_valid_q;
	out_item_t                  out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dry_s1   <= in_data.kind ? '0 : in_data.sample_in;
			gain_s1  <= in_data.loop_gain;
			play_s1  <= play;
			mode_s1  <= mode_nx;
			click_s1 <= in_data.kind ? click : CLICK_NONE;
			led_s1   <= led_nx;

			dry_s2   <= dry_s1;
			prod_s2  <= $signed(rdat_s1) * $signed({1'b0, gain_s1});
			play_s2  <= play_s1;
			mode_s2  <= mode_s1;
			click_s2 <= click_s1;
			led_s2   <= led_s1;
		end
	end

	// floor(loop * gain / 2^15) plus dry, saturated
	logic signed [SAMPLE_W+1:0] scaled;
	logic signed [SAMPLE_W+2:0] mix;
	logic signed [SAMPLE_W-1:0] mix_sat;

	assign scaled = (SAMPLE_W + 2)'(prod_s2 >>> 15);
	assign mix    = (SAMPLE_W + 3)'(dry_s2) + (SAMPLE_W + 3)'(scaled);

	always_comb begin
		if (mix[SAMPLE_W+2:SAMPLE_W-1] == '0 || mix[SAMPLE_W+2:SAMPLE_W-1] == '1) begin
			mix_sat = mix[SAMPLE_W-1:0];
		end else if (mix[SAMPLE_W+2]) begin
			mix_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			mix_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.sample_out  <= play_s2 ? mix_sat : dry_s2;
			out_q.looper_mode <= mode_s2;
			out_q.click_event <= click_s2;
			out_q.led_on      <= led_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_play_pos_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PLAY && len_q != '0) |-> (pos_q < len_q))
		else $error("play position beyond loop length");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= DEPTH_P) && (len_q <= DEPTH_P))
		else $error("position or loop length beyond store depth");

	a_double_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.click_event == CLICK_DOUBLE) |-> out_data.looper_mode == MODE_OFF)
		else $error("double click left looper on");

	a_off_led_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.looper_mode == MODE_OFF) |-> !out_data.led_on)
		else $error("LED lit while off");

	a_click_no_audio: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.click_event != CLICK_NONE) |-> out_data.sample_out == '0)
		else $error("click result carries audio");

endmodule

FILE: verif/audio_looper_record_play_top_test.sv
module audio_looper_record_play_top_test;
	import alrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// small store so the full-store case is reachable in a short run
	localparam int LOOP_DEPTH = 1024;
	localparam int ADDR_W = $clog2(LOOP_DEPTH);
	localparam logic KIND_AUDIO = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;
	localparam logic [31:0] BLINK_MS = 32'd500;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
	localparam int LONG_HOLD = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_REQS = 300;
	localparam int PHASE_REQS = 70;

	typedef struct packed {
		in_item_t  req;
		logic      typed;
		out_item_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// looper state as the block should hold it
	logic [1:0]                 st_mode;
	logic [21:0]                st_pos;
	logic [21:0]                st_len;
	logic                       st_prev_level;
	logic [31:0]                st_last_click;
	logic                       st_led;
	logic signed [SAMPLE_W-1:0] loop_mem [LOOP_DEPTH];
	logic [15:0]                holdoff_ms;
	logic [15:0]                debounce_ms;
	logic [15:0]                dclick_ms;

	out_item_t mix_results_due[$];
	dir_row_t  dir_rows[$];
	int        errors = 0;
	int        reqs_sent = 0;
	logic      calm = 1'b0;
	logic      long_hold_req = 1'b0;

	audio_looper_record_play_top #(.LOOP_DEPTH(LOOP_DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("audio_looper_record_play_top test failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_item_t audio_item(logic [23:0] s, logic [15:0] g);
		in_item_t it;
		it.kind = KIND_AUDIO;
		it.sample_in = s;
		it.loop_gain = g;
		it.button_level = 1'($urandom_range(0, 1));
		it.time_ms = $urandom;
		return it;
	endfunction

	function automatic in_item_t button_item(logic lvl, logic [31:0] t);
		in_item_t it;
		it.kind = KIND_BUTTON;
		it.sample_in = 24'($urandom);
		it.loop_gain = 16'($urandom);
		it.button_level = lvl;
		it.time_ms = t;
		return it;
	endfunction

	function automatic out_item_t looper_out(logic [23:0] s, logic [1:0] m, logic [1:0] c,
			logic l);
		out_item_t r;
		r.sample_out = s;
		r.looper_mode = m;
		r.click_event = c;
		r.led_on = l;
		return r;
	endfunction

	task automatic looper_step(input in_item_t it, output out_item_t res);
		logic [31:0] elapsed;
		logic [1:0]  click;
		longint      mix;
		res = '0;
		click = CLICK_NONE;
		if (st_mode > MODE_PLAY)
			st_mode = MODE_OFF;
		if (it.kind == KIND_BUTTON) begin
			elapsed = it.time_ms - st_last_click;
			if (it.time_ms >= {16'h0, holdoff_ms} && elapsed > {16'h0, debounce_ms} &&
					!st_prev_level && it.button_level)
				click = (elapsed < {16'h0, dclick_ms}) ? CLICK_DOUBLE : CLICK_SINGLE;
			st_prev_level = it.button_level;
			if (click == CLICK_SINGLE) begin
				case (st_mode)
					MODE_OFF: begin
						st_mode = MODE_REC;
						st_pos = '0;
					end
					MODE_REC: begin
						st_mode = MODE_PLAY;
						st_len = st_pos;
						st_pos = '0;
					end
					default: st_mode = MODE_OFF;
				endcase
				st_last_click = it.time_ms;
			end else if (click == CLICK_DOUBLE) begin
				st_mode = MODE_OFF;
				st_last_click = it.time_ms;
			end
			if (st_mode == MODE_PLAY)
				st_led = 1'b1;
			else if (st_mode == MODE_REC)
				st_led = ((it.time_ms / BLINK_MS) % 2 == 0);
			else
				st_led = 1'b0;
		end else begin
			mix = longint'(it.sample_in);
			case (st_mode)
				MODE_REC: begin
					// full store: further samples are dropped
					if (st_pos < LOOP_DEPTH) begin
						loop_mem[st_pos[ADDR_W-1:0]] = it.sample_in;
						st_pos++;
					end
				end
				MODE_PLAY: begin
					if (st_len != 0) begin
						if (st_pos >= st_len)
							st_pos = '0;
						// arithmetic shift gives floor rounding
						mix += (longint'(loop_mem[st_pos[ADDR_W-1:0]]) *
							longint'(it.loop_gain)) >>> 15;
						st_pos++;
						if (st_pos >= st_len)
							st_pos = '0;
					end
				end
				default: st_pos = '0;
			endcase
			if (mix > SAMPLE_MAX)
				mix = SAMPLE_MAX;
			else if (mix < SAMPLE_MIN)
				mix = SAMPLE_MIN;
			res.sample_out = mix[SAMPLE_W-1:0];
		end
		res.looper_mode = st_mode;
		res.click_event = click;
		res.led_on = st_led;
	endtask

	// entered and left just after a falling edge
	task automatic send_req(input in_item_t it, input logic typed = 1'b0,
			input out_item_t typed_res = '0);
		out_item_t res;
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		looper_step(it, res);
		mix_results_due.push_back(typed ? typed_res : res);
		reqs_sent++;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (mix_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val) begin
			$error("reg %0d readback: expected %0d, got %0d", idx, val, prdata[15:0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_HOLDOFF: holdoff_ms = val;
			REG_DEBOUNCE: debounce_ms = val;
			default: dclick_ms = val;
		endcase
	endtask

	task automatic set_timing(input logic [15:0] h, input logic [15:0] d, input logic [15:0] dc);
		wait_drained();
		write_reg(REG_HOLDOFF, h);
		write_reg(REG_DEBOUNCE, d);
		write_reg(REG_DCLICK, dc);
	endtask

	task automatic audio_burst(input int n);
		logic [23:0] s;
		logic [15:0] g;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: s = 24'h7FFFFF;
				1: s = 24'h800000;
				default: s = 24'($urandom);
			endcase
			case ($urandom_range(0, 7))
				0: g = 16'h0000;
				1: g = 16'hFFFF;
				2: g = 16'h8000;
				default: g = 16'($urandom);
			endcase
			send_req(audio_item(s, g));
		end
	endtask

	// release then press, aimed at bounce, double click, single click or hold-off
	task automatic click_try(input logic force_single);
		int unsigned r;
		logic [31:0] e;
		logic [31:0] tp;
		r = force_single ? 60 : $urandom_range(0, 99);
		if (r < 15)
			e = $urandom_range(0, debounce_ms);
		else if (r < 35 && {16'h0, dclick_ms} > {16'h0, debounce_ms} + 32'd1)
			e = $urandom_range(debounce_ms + 1, dclick_ms - 1);
		else
			e = ((debounce_ms > dclick_ms) ? {16'h0, debounce_ms} : {16'h0, dclick_ms}) +
				$urandom_range(1, 1500);
		tp = st_last_click + e;
		if (r >= 95 && holdoff_ms != 0)
			tp = $urandom_range(0, holdoff_ms - 1);
		send_req(button_item(1'b0, tp - $urandom_range(0, e)));
		send_req(button_item(1'b1, tp));
		if ($urandom_range(0, 4) == 0)
			send_req(button_item(1'b1, tp + $urandom_range(0, 50)));
	endtask

	task automatic random_phase(input int n);
		int stop_at;
		in_item_t it;
		stop_at = reqs_sent + n;
		while (reqs_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: audio_burst($urandom_range(1, 24));
				5, 6, 7, 8: click_try(1'b0);
				default: begin
					it.kind = 1'($urandom_range(0, 1));
					it.sample_in = 24'($urandom);
					it.loop_gain = 16'($urandom);
					it.button_level = 1'($urandom_range(0, 1));
					it.time_ms = $urandom;
					send_req(it);
				end
			endcase
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : out_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm) begin
				stall_left = idle_len();
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (mix_results_due.size() == 0) begin
				$error("result with no request outstanding: %h", out_data);
				errors++;
			end else begin
				want = mix_results_due.pop_front();
				if (out_data.sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out,
						out_data.sample_out);
					errors++;
				end
				if (out_data.looper_mode !== want.looper_mode) begin
					$error("looper_mode: expected %0d, got %0d", want.looper_mode,
						out_data.looper_mode);
					errors++;
				end
				if (out_data.click_event !== want.click_event) begin
					$error("click_event: expected %0d, got %0d", want.click_event,
						out_data.click_event);
					errors++;
				end
				if (out_data.led_on !== want.led_on) begin
					$error("led_on: expected %0d, got %0d", want.led_on, out_data.led_on);
					errors++;
				end
			end
		end
	end

	initial begin
		int phase;
		int goal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		st_mode = MODE_OFF;
		st_pos = '0;
		st_len = '0;
		st_prev_level = 1'b0;
		st_last_click = '0;
		st_led = 1'b0;
		holdoff_ms = 16'd1000;
		debounce_ms = 16'd500;
		dclick_ms = 16'd500;

		// reset timing: hold-off 1000, debounce 500, double click 500
		dir_rows.push_back('{audio_item(24'h7FFFFF, 16'hFFFF), 1'b1,
			looper_out(24'h7FFFFF, MODE_OFF, CLICK_NONE, 1'b0)});
		dir_rows.push_back('{audio_item(24'h800000, 16'h0000), 1'b1,
			looper_out(24'h800000, MODE_OFF, CLICK_NONE, 1'b0)});
		// press during hold-off
		dir_rows.push_back('{button_item(1'b1, 32'd999), 1'b1,
			looper_out(24'h0, MODE_OFF, CLICK_NONE, 1'b0)});
		dir_rows.push_back('{button_item(1'b0, 32'd1000), 1'b1,
			looper_out(24'h0, MODE_OFF, CLICK_NONE, 1'b0)});
		dir_rows.push_back('{button_item(1'b1, 32'd1000), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_SINGLE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h7FFFFF, 16'h8000), 1'b1,
			looper_out(24'h7FFFFF, MODE_REC, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h800000, 16'h0001), 1'b1,
			looper_out(24'h800000, MODE_REC, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h000001, 16'h8000), 1'b1,
			looper_out(24'h000001, MODE_REC, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h123456, 16'hFFFF), 1'b1,
			looper_out(24'h123456, MODE_REC, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{button_item(1'b0, 32'd1200), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_NONE, 1'b1)});
		// inside debounce window
		dir_rows.push_back('{button_item(1'b1, 32'd1400), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_NONE, 1'b1)});
		// blink off phase
		dir_rows.push_back('{button_item(1'b0, 32'd1500), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_NONE, 1'b0)});
		dir_rows.push_back('{button_item(1'b1, 32'd1600), 1'b1,
			looper_out(24'h0, MODE_PLAY, CLICK_SINGLE, 1'b1)});
		// saturation both ways
		dir_rows.push_back('{audio_item(24'h7FFFFF, 16'hFFFF), 1'b1,
			looper_out(24'h7FFFFF, MODE_PLAY, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h800000, 16'hFFFF), 1'b1,
			looper_out(24'h800000, MODE_PLAY, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h000000, 16'h8000), 1'b1,
			looper_out(24'h000001, MODE_PLAY, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h000000, 16'h0001), 1'b0, '0});
		// loop wraps back to the first entry
		dir_rows.push_back('{audio_item(24'hFFFFFF, 16'h8000), 1'b0, '0});
		dir_rows.push_back('{audio_item(24'h000000, 16'h0003), 1'b0, '0});
		dir_rows.push_back('{button_item(1'b0, 32'hFFFFFB00), 1'b1,
			looper_out(24'h0, MODE_PLAY, CLICK_NONE, 1'b1)});
		dir_rows.push_back('{button_item(1'b1, 32'hFFFFFC00), 1'b1,
			looper_out(24'h0, MODE_OFF, CLICK_SINGLE, 1'b0)});
		// time counter wraps past zero
		dir_rows.push_back('{button_item(1'b0, 32'h00000100), 1'b1,
			looper_out(24'h0, MODE_OFF, CLICK_NONE, 1'b0)});
		dir_rows.push_back('{button_item(1'b1, 32'h00000400), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_SINGLE, 1'b1)});
		dir_rows.push_back('{button_item(1'b0, 32'h00000500), 1'b1,
			looper_out(24'h0, MODE_REC, CLICK_NONE, 1'b1)});
		// play with nothing recorded
		dir_rows.push_back('{button_item(1'b1, 32'h00000700), 1'b1,
			looper_out(24'h0, MODE_PLAY, CLICK_SINGLE, 1'b1)});
		dir_rows.push_back('{audio_item(24'h345678, 16'hFFFF), 1'b1,
			looper_out(24'h345678, MODE_PLAY, CLICK_NONE, 1'b1)});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

		phase = 0;
		goal = reqs_sent + RANDOM_REQS;
		while (reqs_sent < goal) begin
			case (phase)
				0: ;
				1: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_timing(16'd300, 16'd40, 16'd250);
				3: set_timing(16'd0, 16'd100, 16'd600);
				default: begin
					if ($urandom_range(0, 3) == 0)
						set_timing(16'($urandom), 16'($urandom), 16'($urandom));
					else
						set_timing(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 300)),
							16'($urandom_range(0, 900)));
				end
			endcase
			if (phase == 2) begin
				// receiver holds while requests keep coming, pipeline backs up
				long_hold_req = 1'b1;
				calm = 1'b1;
				audio_burst(40);
			end
			calm = (phase % 4 == 3);
			random_phase(PHASE_REQS);
			phase++;
		end
		calm = 1'b0;

		// record past the end of the store, then play the start of the full loop
		set_timing(16'd0, 16'd0, 16'd0);
		while (st_mode != MODE_REC)
			click_try(1'b1);
		calm = 1'b1;
		audio_burst(LOOP_DEPTH + 8);
		calm = 1'b0;
		while (st_mode != MODE_PLAY)
			click_try(1'b1);
		audio_burst(60);

		wait_drained();
		if (errors == 0)
			$display("audio_looper_record_play_top test passed");
		else
			$display("audio_looper_record_play_top test failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/alrp_pkg.sv
hw/rtl/audio_looper_record_play_top.sv
verif/audio_looper_record_play_top_test.sv
